### design/sls_pkg.sv
// ----------------------------------------------------------------------------
// Scaling lambda schedule package
// Shared codes, command and status types, and fixed-point constants.
// ----------------------------------------------------------------------------
package sls_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_START  = 3'd0;
	localparam logic [2:0] REG_EQUIL  = 3'd1;
	localparam logic [2:0] REG_SWITCH = 3'd2;
	localparam logic [2:0] REG_LINIT  = 3'd3;
	localparam logic [2:0] REG_LFINAL = 3'd4;
	localparam logic [2:0] REG_MODE   = 3'd5;
	localparam logic [2:0] NUM_REGS   = 3'd6;

	// Switching modes.
	localparam logic [1:0] MODE_LIN   = 2'd0;
	localparam logic [1:0] MODE_RECIP = 2'd1;
	localparam logic [1:0] MODE_RLOG  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Fixed-point constants.
	localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
	localparam logic [31:0] LN2_Q32    = 32'd2977044472;
	localparam logic [30:0] LAMBDA_MAX = 31'h7FFF_FFFF;
	localparam logic [62:0] MAG_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] LAMBDA_RST = 31'd65536;

	// Datapath operation codes issued by the controller.
	localparam logic [5:0] OP_NONE      = 6'd0;
	localparam logic [5:0] OP_TICK      = 6'd1;
	localparam logic [5:0] OP_RELOAD    = 6'd2;
	localparam logic [5:0] OP_DIV_U     = 6'd3;
	localparam logic [5:0] OP_WR_U      = 6'd4;
	localparam logic [5:0] OP_MUL_STEP  = 6'd5;
	localparam logic [5:0] OP_WR_STEP   = 6'd6;
	localparam logic [5:0] OP_DIV_LMAG  = 6'd7;
	localparam logic [5:0] OP_WR_MAG    = 6'd8;
	localparam logic [5:0] OP_LOG       = 6'd9;
	localparam logic [5:0] OP_WR_F_LOG  = 6'd10;
	localparam logic [5:0] OP_WR_F_U    = 6'd11;
	localparam logic [5:0] OP_MUL_D1    = 6'd12;
	localparam logic [5:0] OP_WR_D1     = 6'd13;
	localparam logic [5:0] OP_MUL_D2    = 6'd14;
	localparam logic [5:0] OP_WR_D2     = 6'd15;
	localparam logic [5:0] OP_MUL_PP    = 6'd16;
	localparam logic [5:0] OP_WR_PP     = 6'd17;
	localparam logic [5:0] OP_DIV_LAM   = 6'd18;
	localparam logic [5:0] OP_WR_LAM    = 6'd19;
	localparam logic [5:0] OP_MUL_SQ    = 6'd20;
	localparam logic [5:0] OP_WR_SQ     = 6'd21;
	localparam logic [5:0] OP_MUL_SQD   = 6'd22;
	localparam logic [5:0] OP_DIV_A     = 6'd23;
	localparam logic [5:0] OP_DIV_S     = 6'd24;
	localparam logic [5:0] OP_MUL_M     = 6'd25;
	localparam logic [5:0] OP_WR_M      = 6'd26;
	localparam logic [5:0] OP_DIV_M     = 6'd27;
	localparam logic [5:0] OP_SAT_MAG   = 6'd28;
	localparam logic [5:0] OP_ZERO      = 6'd29;
	localparam logic [5:0] OP_FIN       = 6'd30;
	localparam logic [5:0] OP_FMUL      = 6'd31;
	localparam logic [5:0] OP_OUT_TICK  = 6'd32;
	localparam logic [5:0] OP_OUT_FORCE = 6'd33;

	// Controller to datapath.
	typedef struct packed {
		logic [5:0] op;
		logic       cap_in;
		logic       cap_cfg;
	} sls_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic log_busy;
		logic fwd;
		logic rev;
		logic lin;
		logic logm;
		logic zero_end;
		logic q_big;
	} sls_stat_t;

endpackage

### design/scaling_lambda_schedule_core.sv
// ----------------------------------------------------------------------------
// Scaling lambda schedule core
// Coupling schedule for reversible scaling runs with force scaling.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream; s_tuser selects a step tick (0) or a
// force item (1). Every item yields exactly one result item on the m_ stream
// carrying the current lambda and slope, plus the forces (scaled if in_group) for a force
// item or zero forces for a tick. Registers are written on the cfg_ channel,
// which is taken only while the core is idle; a write to a known register
// recomputes lambda and slope at the start of the schedule.
// A force item passes through the FMUL and FOUT states, and a tick outside both
// windows through the TICK and OUT states; each waits in its output state while
// an earlier result waits for m_tready. A tick inside a window runs the update
// sequence on a shared serial divider and a serial multiplier, with more
// multiplications and divisions for reciprocal mode and the log2 law, which also uses the log2 unit.
// A configuration write runs the same update sequence and gives no result.
// One item is processed at a time; the output register lets the next item
// be accepted while a result waits for m_tready, and a stalled receiver
// holds the core only when a new result is ready to be written.
// After reset lambda is 1.0 (65536), the slope is zero and no result waits.
// ----------------------------------------------------------------------------
module scaling_lambda_schedule_core import sls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,   // timestep, in_group, force_x, force_y, force_z
	input  logic         s_tuser,   // cmd
	input  logic         s_tlast,   // last_atom
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // lambda_out, slope_out, force_x_out, force_y_out,
	                                // force_z_out
	output logic         m_tlast,   // last_atom_out
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);

	sls_cmd_t  cmd;
	sls_stat_t stat;

	sls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.stat      (stat),
		.cmd       (cmd)
	);

	sls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### design/sls_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add 64 x 64 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sls_mul import sls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         busy,
	output logic [127:0] prod
);

	logic [127:0] acc_q;
	logic [127:0] mc_q;
	logic [63:0]  mp_q;
	logic         busy_q;

	// Busy ends once no multiplier bits remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= (b != 64'd0);
		end else if (busy_q) begin
			busy_q <= (mp_q[63:1] != 63'd0);
		end
	end

	// Accumulate the shifted multiplicand.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 128'd0;
			mc_q  <= {64'd0, a};
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[126:0], 1'b0};
			mp_q <= {1'b0, mp_q[63:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

### design/sls_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 128 / 64 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sls_div import sls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] dividend,
	input  logic [63:0]  divisor,
	output logic         busy,
	output logic [127:0] quot
);

	logic [127:0] nq_q;
	logic [63:0]  rem_q;
	logic [63:0]  dv_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic [64:0]  trial;
	logic [64:0]  diff;
	logic         qbit;

	// One restoring step on the running remainder.
	always_comb begin
		trial = {rem_q, nq_q[127]};
		diff  = trial - {1'b0, dv_q};
		qbit  = (trial >= {1'b0, dv_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd127) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend bits shift out at the top, quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= dividend;
			rem_q <= 64'd0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			nq_q  <= {nq_q[126:0], qbit};
			rem_q <= qbit ? diff[63:0] : trial[63:0];
		end
	end

	assign busy = busy_q;
	assign quot = nq_q;

endmodule

### design/sls_dp.sv
// ----------------------------------------------------------------------------
// Scaling lambda schedule datapath
// Configuration, coupling state, window check, arithmetic units and the
// force scaling path, all driven by operation codes from the controller.
// ----------------------------------------------------------------------------
module sls_dp import sls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  sls_cmd_t      cmd,
	output sls_stat_t     stat,
	input  logic [151:0]  s_tdata,
	input  logic          s_tlast,
	input  logic [2:0]    cfg_index,
	input  logic [47:0]   cfg_data,
	output logic [191:0]  m_tdata,
	output logic          m_tlast
);

	// Configuration registers.
	logic [47:0] start_q;
	logic [31:0] equil_q;
	logic [31:0] switch_q;
	logic [30:0] linit_q;
	logic [30:0] lfinal_q;
	logic [1:0]  mode_q;

	// Coupling state and work registers.
	logic [30:0] lam_q;
	logic [63:0] slope_q;
	logic [62:0] mag_q;
	logic [31:0] n_q;
	logic        rev_q;
	logic [32:0] u_q;
	logic [32:0] f_q;
	logic [63:0] den_q;
	logic [61:0] pp_q;
	logic [61:0] sq_q;
	logic [32:0] m_q;

	// Captured input item.
	logic [47:0] ts_q;
	logic        grp_q;
	logic [31:0] fx_q, fy_q, fz_q;
	logic        last_q;
	logic signed [63:0] px_s1, py_s1, pz_s1;

	// Log unit.
	logic [32:0] lx_q;
	logic [65:0] lsq_q;
	logic [31:0] lres_q;
	logic [4:0]  lcnt_q;
	logic        lph_q;
	logic        lbusy_q;
	logic [33:0] lnext;

	// Output register.
	logic [30:0] lam_out_q;
	logic [63:0] slope_out_q;
	logic [31:0] fx_out_q, fy_out_q, fz_out_q;
	logic        last_out_q;

	// Shared units.
	logic         mul_start, div_start;
	logic [63:0]  mul_a, mul_b, div_dv;
	logic [127:0] div_nd;
	logic [127:0] prod, quot;
	logic         mul_busy, div_busy;

	// Derived values.
	logic [31:0]        s_eff;
	logic               up;
	logic [30:0]        dlt;
	logic [48:0]        base;
	logic signed [50:0] t;
	logic [33:0]        e_s, e_2s, n_rev;
	logic               fwd, rev;
	logic [31:0]        step;

	// Truncate toward zero by 2^16 and saturate to 32 bits.
	function automatic logic [31:0] sat_scale(input logic signed [63:0] p);
		logic signed [47:0] v;
		v = p[63:16];
		if (p[63] && (p[15:0] != 16'd0)) begin
			v = v + 48'sd1;
		end
		if (v > 48'sd2147483647) begin
			sat_scale = 32'h7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			sat_scale = 32'h8000_0000;
		end else begin
			sat_scale = v[31:0];
		end
	endfunction

	// Schedule geometry and step window.
	always_comb begin
		s_eff = (switch_q == 32'd0) ? 32'd1 : switch_q;
		up    = (lfinal_q >= linit_q);
		dlt   = up ? (lfinal_q - linit_q) : (linit_q - lfinal_q);
		base  = {1'b0, start_q} + {17'd0, equil_q};
		t     = $signed({3'b000, ts_q}) - $signed({2'b00, base});
		e_s   = {2'b00, equil_q} + {2'b00, s_eff};
		e_2s  = e_s + {2'b00, s_eff};
		n_rev = e_2s - t[33:0];
		fwd   = !t[50] && (t <= $signed({19'd0, s_eff}));
		rev   = !t[50] && (t >= $signed({17'd0, e_s})) && (t <= $signed({17'd0, e_2s}));
		step  = prod[63:32];
	end

	// Multiplier operand selection.
	always_comb begin
		mul_start = 1'b1;
		mul_a     = 64'd0;
		mul_b     = 64'd0;
		unique case (cmd.op)
			OP_MUL_STEP: begin
				mul_a = {33'd0, dlt};
				mul_b = {31'd0, u_q};
			end
			OP_MUL_D1: begin
				mul_a = {33'd0, lfinal_q};
				mul_b = {31'd0, ONE_Q32 - f_q};
			end
			OP_MUL_D2: begin
				mul_a = {33'd0, linit_q};
				mul_b = {31'd0, f_q};
			end
			OP_MUL_PP: begin
				mul_a = {33'd0, linit_q};
				mul_b = {33'd0, lfinal_q};
			end
			OP_MUL_SQ: begin
				mul_a = {33'd0, lam_q};
				mul_b = {33'd0, lam_q};
			end
			OP_MUL_SQD: begin
				mul_a = {2'd0, sq_q};
				mul_b = {33'd0, dlt};
			end
			OP_MUL_M: begin
				mul_a = {32'd0, LN2_Q32};
				mul_b = {31'd0, u_q};
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Divider operand selection.
	always_comb begin
		div_start = 1'b1;
		div_nd    = 128'd0;
		div_dv    = 64'd1;
		unique case (cmd.op)
			OP_DIV_U: begin
				div_nd = {64'd0, n_q, 32'd0};
				div_dv = {32'd0, s_eff};
			end
			OP_DIV_LMAG: begin
				div_nd = {64'd0, 1'b0, dlt, 32'd0};
				div_dv = {32'd0, s_eff};
			end
			OP_DIV_LAM: begin
				div_nd = {34'd0, pp_q, 32'd0};
				div_dv = den_q;
			end
			OP_DIV_A: begin
				div_nd = {prod[95:0], 32'd0};
				div_dv = {2'd0, pp_q};
			end
			OP_DIV_S: begin
				div_nd = quot;
				div_dv = {32'd0, s_eff};
			end
			OP_DIV_M: begin
				div_nd = {quot[95:0], 32'd0};
				div_dv = {31'd0, m_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	sls_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (prod)
	);

	sls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.busy     (div_busy),
		.quot     (quot)
	);

	// Configuration registers and coupling state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 48'd0;
			equil_q  <= 32'd0;
			switch_q <= 32'd1;
			linit_q  <= LAMBDA_RST;
			lfinal_q <= LAMBDA_RST;
			mode_q   <= MODE_LIN;
			lam_q    <= LAMBDA_RST;
			slope_q  <= 64'd0;
		end else begin
			if (cmd.cap_cfg) begin
				unique case (cfg_index)
					REG_START:  start_q  <= cfg_data;
					REG_EQUIL:  equil_q  <= cfg_data[31:0];
					REG_SWITCH: switch_q <= cfg_data[31:0];
					REG_LINIT:  linit_q  <= cfg_data[30:0];
					REG_LFINAL: lfinal_q <= cfg_data[30:0];
					REG_MODE:   mode_q   <= cfg_data[1:0];
					default:    ;
				endcase
			end
			unique case (cmd.op)
				OP_WR_STEP: lam_q <= up ? (linit_q + step[30:0]) : (linit_q - step[30:0]);
				OP_WR_LAM:  lam_q <= (quot[127:31] != 97'd0) ? LAMBDA_MAX : quot[30:0];
				OP_ZERO:    lam_q <= 31'd0;
				OP_FIN:     slope_q <= (up != rev_q) ? {1'b0, mag_q} : (64'd0 - {1'b0, mag_q});
				default:    ;
			endcase
		end
	end

	// Work registers of the update sequence.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TICK: begin
				if (rev) begin
					n_q   <= n_rev[31:0];
					rev_q <= 1'b1;
				end else begin
					n_q   <= t[31:0];
					rev_q <= 1'b0;
				end
			end
			OP_RELOAD: begin
				n_q   <= 32'd0;
				rev_q <= 1'b0;
			end
			OP_WR_U:     u_q   <= quot[32:0];
			OP_WR_F_LOG: f_q   <= u_q[32] ? ONE_Q32 : {1'b0, lres_q};
			OP_WR_F_U:   f_q   <= u_q;
			OP_WR_D1:    den_q <= prod[63:0];
			OP_WR_D2:    den_q <= den_q + prod[63:0];
			OP_WR_PP:    pp_q  <= prod[61:0];
			OP_WR_SQ:    sq_q  <= prod[61:0];
			OP_WR_M:     m_q   <= {1'b0, LN2_Q32} + prod[64:32];
			OP_WR_MAG:   mag_q <= (quot[127:63] != 65'd0) ? MAG_MAX : quot[62:0];
			OP_SAT_MAG:  mag_q <= MAG_MAX;
			OP_ZERO:     mag_q <= 63'd0;
			default:     ;
		endcase
	end

	// Log2(1+u): repeated squaring, a squaring phase and a normalizing phase per result bit.
	assign lnext = lsq_q[65:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbusy_q <= 1'b0;
			lph_q   <= 1'b0;
			lcnt_q  <= 5'd0;
		end else if (cmd.op == OP_LOG) begin
			lbusy_q <= 1'b1;
			lph_q   <= 1'b0;
			lcnt_q  <= 5'd31;
		end else if (lbusy_q) begin
			lph_q <= !lph_q;
			if (lph_q) begin
				lcnt_q <= lcnt_q - 5'd1;
				if (lcnt_q == 5'd0) begin
					lbusy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOG) begin
			lx_q   <= {1'b1, u_q[31:0]};
			lres_q <= 32'd0;
		end else if (lbusy_q) begin
			if (!lph_q) begin
				lsq_q <= lx_q * lx_q;
			end else if (lnext[33]) begin
				lx_q           <= lnext[33:1];
				lres_q[lcnt_q] <= 1'b1;
			end else begin
				lx_q <= lnext[32:0];
			end
		end
	end

	// Input capture and force products.
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			ts_q   <= s_tdata[47:0];
			grp_q  <= s_tdata[48];
			fx_q   <= s_tdata[80:49];
			fy_q   <= s_tdata[112:81];
			fz_q   <= s_tdata[144:113];
			last_q <= s_tlast;
		end
		if (cmd.op == OP_FMUL) begin
			px_s1 <= $signed(fx_q) * $signed({1'b0, lam_q});
			py_s1 <= $signed(fy_q) * $signed({1'b0, lam_q});
			pz_s1 <= $signed(fz_q) * $signed({1'b0, lam_q});
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT_TICK) begin
			lam_out_q   <= lam_q;
			slope_out_q <= slope_q;
			fx_out_q    <= 32'd0;
			fy_out_q    <= 32'd0;
			fz_out_q    <= 32'd0;
			last_out_q  <= 1'b0;
		end else if (cmd.op == OP_OUT_FORCE) begin
			lam_out_q   <= lam_q;
			slope_out_q <= slope_q;
			fx_out_q    <= grp_q ? sat_scale(px_s1) : fx_q;
			fy_out_q    <= grp_q ? sat_scale(py_s1) : fy_q;
			fz_out_q    <= grp_q ? sat_scale(pz_s1) : fz_q;
			last_out_q  <= last_q;
		end
	end

	assign m_tdata = {1'b0, fz_out_q, fy_out_q, fx_out_q, slope_out_q, lam_out_q};
	assign m_tlast = last_out_q;

	// Status to the controller.
	always_comb begin
		stat.mul_busy = mul_busy;
		stat.div_busy = div_busy;
		stat.log_busy = lbusy_q;
		stat.fwd      = fwd;
		stat.rev      = rev;
		stat.lin      = (mode_q == MODE_LIN) || (mode_q == MODE_SPARE);
		stat.logm     = (mode_q == MODE_RLOG);
		stat.zero_end = (linit_q == 31'd0) || (lfinal_q == 31'd0);
		stat.q_big    = (quot[127:96] != 32'd0);
	end

endmodule

### design/sls_ctrl.sv
// ----------------------------------------------------------------------------
// Scaling lambda schedule controller
// State machine that accepts items and configuration writes and steps the
// datapath through the schedule update and force scaling sequences.
// ----------------------------------------------------------------------------
module sls_ctrl import sls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      s_tuser,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_index,
	input  sls_stat_t stat,
	output sls_cmd_t  cmd
);

	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_RLD   = 6'd1;
	localparam logic [5:0] S_TICK  = 6'd2;
	localparam logic [5:0] S_DU    = 6'd3;
	localparam logic [5:0] S_DU_W  = 6'd4;
	localparam logic [5:0] S_LM    = 6'd5;
	localparam logic [5:0] S_LM_W  = 6'd6;
	localparam logic [5:0] S_LD    = 6'd7;
	localparam logic [5:0] S_LD_W  = 6'd8;
	localparam logic [5:0] S_ZERO  = 6'd9;
	localparam logic [5:0] S_LG    = 6'd10;
	localparam logic [5:0] S_LG_W  = 6'd11;
	localparam logic [5:0] S_FU    = 6'd12;
	localparam logic [5:0] S_D1    = 6'd13;
	localparam logic [5:0] S_D1_W  = 6'd14;
	localparam logic [5:0] S_D2    = 6'd15;
	localparam logic [5:0] S_D2_W  = 6'd16;
	localparam logic [5:0] S_PP    = 6'd17;
	localparam logic [5:0] S_PP_W  = 6'd18;
	localparam logic [5:0] S_DL    = 6'd19;
	localparam logic [5:0] S_DL_W  = 6'd20;
	localparam logic [5:0] S_SQ    = 6'd21;
	localparam logic [5:0] S_SQ_W  = 6'd22;
	localparam logic [5:0] S_SQD   = 6'd23;
	localparam logic [5:0] S_SQD_W = 6'd24;
	localparam logic [5:0] S_DA    = 6'd25;
	localparam logic [5:0] S_DA_W  = 6'd26;
	localparam logic [5:0] S_DS    = 6'd27;
	localparam logic [5:0] S_DS_W  = 6'd28;
	localparam logic [5:0] S_MM    = 6'd29;
	localparam logic [5:0] S_MM_W  = 6'd30;
	localparam logic [5:0] S_SATM  = 6'd31;
	localparam logic [5:0] S_DM    = 6'd32;
	localparam logic [5:0] S_DM_W  = 6'd33;
	localparam logic [5:0] S_FIN   = 6'd34;
	localparam logic [5:0] S_OUT   = 6'd35;
	localparam logic [5:0] S_FMUL  = 6'd36;
	localparam logic [5:0] S_FOUT  = 6'd37;

	logic [5:0] state_q, state_d;
	logic       emit_q, emit_d;
	logic       valid_q;
	logic       out_free;
	logic       out_load;

	assign out_free = !valid_q || m_tready;

	// Next state and datapath command.
	always_comb begin
		state_d     = state_q;
		emit_d      = emit_q;
		cmd.op      = OP_NONE;
		cmd.cap_in  = 1'b0;
		cmd.cap_cfg = 1'b0;
		s_tready    = 1'b0;
		cfg_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cap_cfg = 1'b1;
					if (cfg_index < NUM_REGS) begin
						emit_d  = 1'b0;
						state_d = S_RLD;
					end
				end else if (s_tvalid) begin
					cmd.cap_in = 1'b1;
					state_d    = s_tuser ? S_FMUL : S_TICK;
				end
			end
			S_RLD: begin
				cmd.op  = OP_RELOAD;
				state_d = S_DU;
			end
			S_TICK: begin
				cmd.op = OP_TICK;
				if (stat.fwd || stat.rev) begin
					emit_d  = 1'b1;
					state_d = S_DU;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DU: begin
				cmd.op  = OP_DIV_U;
				state_d = S_DU_W;
			end
			S_DU_W: begin
				if (!stat.div_busy) begin
					cmd.op = OP_WR_U;
					priority if (stat.lin) begin
						state_d = S_LM;
					end else if (stat.zero_end) begin
						state_d = S_ZERO;
					end else if (stat.logm) begin
						state_d = S_LG;
					end else begin
						state_d = S_FU;
					end
				end
			end
			S_LM: begin
				cmd.op  = OP_MUL_STEP;
				state_d = S_LM_W;
			end
			S_LM_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_STEP;
					state_d = S_LD;
				end
			end
			S_LD: begin
				cmd.op  = OP_DIV_LMAG;
				state_d = S_LD_W;
			end
			S_LD_W: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_WR_MAG;
					state_d = S_FIN;
				end
			end
			S_ZERO: begin
				cmd.op  = OP_ZERO;
				state_d = S_FIN;
			end
			S_LG: begin
				cmd.op  = OP_LOG;
				state_d = S_LG_W;
			end
			S_LG_W: begin
				if (!stat.log_busy) begin
					cmd.op  = OP_WR_F_LOG;
					state_d = S_D1;
				end
			end
			S_FU: begin
				cmd.op  = OP_WR_F_U;
				state_d = S_D1;
			end
			S_D1: begin
				cmd.op  = OP_MUL_D1;
				state_d = S_D1_W;
			end
			S_D1_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_D1;
					state_d = S_D2;
				end
			end
			S_D2: begin
				cmd.op  = OP_MUL_D2;
				state_d = S_D2_W;
			end
			S_D2_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_D2;
					state_d = S_PP;
				end
			end
			S_PP: begin
				cmd.op  = OP_MUL_PP;
				state_d = S_PP_W;
			end
			S_PP_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_PP;
					state_d = S_DL;
				end
			end
			S_DL: begin
				cmd.op  = OP_DIV_LAM;
				state_d = S_DL_W;
			end
			S_DL_W: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_WR_LAM;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.op  = OP_MUL_SQ;
				state_d = S_SQ_W;
			end
			S_SQ_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_SQ;
					state_d = S_SQD;
				end
			end
			S_SQD: begin
				cmd.op  = OP_MUL_SQD;
				state_d = S_SQD_W;
			end
			S_SQD_W: begin
				if (!stat.mul_busy) begin
					state_d = S_DA;
				end
			end
			S_DA: begin
				cmd.op  = OP_DIV_A;
				state_d = S_DA_W;
			end
			S_DA_W: begin
				if (!stat.div_busy) begin
					state_d = S_DS;
				end
			end
			S_DS: begin
				cmd.op  = OP_DIV_S;
				state_d = S_DS_W;
			end
			S_DS_W: begin
				if (!stat.div_busy) begin
					if (stat.logm) begin
						state_d = S_MM;
					end else begin
						cmd.op  = OP_WR_MAG;
						state_d = S_FIN;
					end
				end
			end
			S_MM: begin
				cmd.op  = OP_MUL_M;
				state_d = S_MM_W;
			end
			S_MM_W: begin
				if (!stat.mul_busy) begin
					cmd.op  = OP_WR_M;
					state_d = stat.q_big ? S_SATM : S_DM;
				end
			end
			S_SATM: begin
				cmd.op  = OP_SAT_MAG;
				state_d = S_FIN;
			end
			S_DM: begin
				cmd.op  = OP_DIV_M;
				state_d = S_DM_W;
			end
			S_DM_W: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_WR_MAG;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = emit_q ? S_OUT : S_IDLE;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op  = OP_OUT_TICK;
					state_d = S_IDLE;
				end
			end
			S_FMUL: begin
				cmd.op  = OP_FMUL;
				state_d = S_FOUT;
			end
			S_FOUT: begin
				if (out_free) begin
					cmd.op  = OP_OUT_FORCE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_load = (cmd.op == OP_OUT_TICK) || (cmd.op == OP_OUT_FORCE);

	// State, result flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;

endmodule
